// ===== rtl/rcts_pkg.sv =====
`timescale 1ns / 1ps

package rcts_pkg;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  localparam logic [2:0] CFG_CYCLES_PER_LINE = 3'd0;
  localparam logic [2:0] CFG_LINES_PER_TICK  = 3'd1;
  localparam logic [2:0] CFG_TABLE_LENGTH    = 3'd2;
  localparam logic [2:0] CFG_MUSIC_ENABLED   = 3'd3;
  localparam logic [2:0] CFG_RATE_INCREMENT  = 3'd4;

  localparam int MILLI = 1000;

  // ceil(2^31 / 1000); exact quotient for products below 2^22
  localparam logic [21:0] MILLI_RECIP = 22'd2147484;
  localparam int          MILLI_SHIFT = 31;

  typedef struct packed {
    logic [15:0]        cycles_per_line_milli;
    logic [5:0]         lines_per_tick;
    logic [8:0]         table_length;
    logic               music_enabled;
    logic signed [11:0] rate_increment;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic start;
    logic stop;
    logic mul;
    logic div_step;
    logic dither;
    logic rd;
    logic step;
    logic tune_a;
    logic tune_b;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic div_last;
    logic count_zero;
    logic wrap_now;
    logic music;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/rcts_ctrl.sv =====
`timescale 1ns / 1ps

module rcts_ctrl import rcts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_kind,
  output logic       in_tready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_DITHER = 9'b000001000,
    S_READ   = 9'b000010000,
    S_STEP   = 9'b000100000,
    S_TUNE_A = 9'b001000000,
    S_TUNE_B = 9'b010000000,
    S_PUSH   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_kind)
            KIND_LOAD: cmd.load = 1'b1;
            KIND_START: begin
              cmd.start = 1'b1;
              state_nxt = S_MUL;
            end
            KIND_TICK: begin
              if (sts.running) begin
                state_nxt = S_DITHER;
              end
            end
            KIND_STOP: cmd.stop = 1'b1;
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DITHER: begin
        cmd.dither = 1'b1;
        state_nxt  = sts.count_zero ? S_IDLE : S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = (sts.wrap_now && sts.music) ? S_TUNE_A : S_PUSH;
      end
      S_TUNE_A: begin
        cmd.tune_a = 1'b1;
        state_nxt  = S_TUNE_B;
      end
      S_TUNE_B: begin
        cmd.tune_b = 1'b1;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = sts.last ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/rcts_datapath.sv =====
`timescale 1ns / 1ps

module rcts_datapath import rcts_pkg::*; #(
  parameter int TABLE_DEPTH    = 256,
  parameter int RATE_SCALE     = 1024,
  parameter int RESTART_FRAMES = 12000,
  parameter int MAX_LINES      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  entry_color,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tuser
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LENW = (AW + 1 > 9) ? AW + 1 : 9;
  localparam int LW   = $clog2(MAX_LINES + 1);
  localparam int LCW  = (LW > 6) ? LW : 6;
  localparam int TW   = 16 + LW;
  localparam int PW   = TW + 22;
  localparam int TAW  = ($clog2(RATE_SCALE) + 2 > 13) ? $clog2(RATE_SCALE) + 2 : 13;

  localparam logic signed [TAW-1:0] RS_S = TAW'(RATE_SCALE);
  localparam logic [15:0]           RF   = 16'(RESTART_FRAMES);

  function automatic logic [AW-1:0] idx_mod(input logic [7:0] idx);
    logic [AW:0] rem;
    rem = '0;
    for (int i = 7; i >= 0; i--) begin
      rem = {rem[AW-1:0], idx[i]};
      if (rem >= (AW+1)'(TABLE_DEPTH)) begin
        rem = rem - (AW+1)'(TABLE_DEPTH);
      end
    end
    return rem[AW-1:0];
  endfunction

  logic [7:0]            mem [TABLE_DEPTH];
  logic [7:0]            rd_data_r;
  logic                  running_r;
  logic [TW-1:0]         tot_r;
  logic [TW-1:0]         q_r;
  logic [9:0]            rem_r;
  logic                  div_cnt_r;
  logic [9:0]            acc_r;
  logic [15:0]           reload_r;
  logic [AW-1:0]         pos_r;
  logic [LW-1:0]         n_r;
  logic [15:0]           frame_r;
  logic                  wrap_r;
  logic                  last_r;
  logic signed [TAW-1:0] tempo_r;
  logic [1:0]            due_r;
  logic [15:0]           tune_cnt_r;
  logic [1:0]            plays_r;
  logic                  restart_r;
  logic                  out_valid_r;
  logic [47:0]           out_data_r;
  logic                  out_last_r;
  logic                  out_user_r;

  logic [LCW-1:0]        lines_ext;
  logic [LW-1:0]         eff_lines;
  logic [TW-1:0]         product;
  logic [PW-1:0]         rec_prod;
  logic [TW-1:0]         q_times;
  logic [TW-1:0]         rem_full;
  logic [10:0]           dsum;
  logic [AW:0]           pos_inc;
  logic [LENW-1:0]       tl_ext;
  logic [LENW-1:0]       eff_len;
  logic                  wrap_now;
  logic                  last_now;
  logic signed [TAW-1:0] inc_ext;
  logic signed [TAW-1:0] inc_eff;
  logic signed [TAW-1:0] tmp;
  logic [15:0]           c1;
  logic [15:0]           c2;

  assign lines_ext = LCW'(cfg.lines_per_tick);
  assign eff_lines = (lines_ext > LCW'(MAX_LINES)) ? LW'(MAX_LINES) : LW'(lines_ext);
  assign product   = TW'(cfg.cycles_per_line_milli) * TW'(eff_lines);

  // quotient by reciprocal multiply, then remainder from the registered quotient
  assign rec_prod = PW'(tot_r) * PW'(MILLI_RECIP);
  assign q_times  = q_r * TW'(MILLI);
  assign rem_full = tot_r - q_times;
  assign dsum     = {1'b0, acc_r} + {1'b0, rem_r};

  assign pos_inc  = {1'b0, pos_r} + (AW+1)'(1);
  assign tl_ext   = LENW'(cfg.table_length);
  assign eff_len  = (tl_ext > LENW'(TABLE_DEPTH)) ? LENW'(TABLE_DEPTH) : tl_ext;
  assign wrap_now = (LENW'(pos_inc) >= eff_len);
  assign last_now = wrap_now || (({1'b0, n_r} + (LW+1)'(1)) == {1'b0, eff_lines});

  assign inc_ext = TAW'(cfg.rate_increment);
  assign inc_eff = (inc_ext > RS_S) ? RS_S : ((inc_ext < -RS_S) ? -RS_S : inc_ext);
  assign tmp     = tempo_r + inc_eff;
  assign c1      = tune_cnt_r + 16'd1;
  assign c2      = c1 + 16'd1;

  assign sts.running    = running_r;
  assign sts.div_last   = div_cnt_r;
  assign sts.count_zero = (eff_lines == '0);
  assign sts.wrap_now   = wrap_now;
  assign sts.music      = cfg.music_enabled;
  assign sts.last       = last_r;
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[idx_mod(entry_index)] <= entry_color;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      tot_r       <= '0;
      q_r         <= '0;
      rem_r       <= '0;
      div_cnt_r   <= 1'b0;
      acc_r       <= '0;
      pos_r       <= '0;
      frame_r     <= '0;
      tempo_r     <= '0;
      tune_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        running_r <= 1'b1;
        pos_r     <= '0;
        acc_r     <= '0;
        frame_r   <= '0;
      end
      if (cmd.stop) begin
        running_r <= 1'b0;
      end
      if (cmd.mul) begin
        tot_r     <= product;
        rem_r     <= '0;
        div_cnt_r <= 1'b0;
      end
      if (cmd.div_step) begin
        if (!div_cnt_r) begin
          q_r <= TW'(rec_prod[PW-1:MILLI_SHIFT]);
        end else begin
          rem_r <= rem_full[9:0];
        end
        div_cnt_r <= !div_cnt_r;
      end
      if (cmd.dither) begin
        if (dsum >= 11'(MILLI)) begin
          acc_r    <= 10'(dsum - 11'(MILLI));
          reload_r <= q_r[15:0] + 16'd1;
        end else begin
          acc_r    <= dsum[9:0];
          reload_r <= q_r[15:0];
        end
        n_r <= '0;
      end
      if (cmd.step) begin
        pos_r     <= wrap_now ? '0 : pos_inc[AW-1:0];
        frame_r   <= frame_r + 16'(wrap_now);
        wrap_r    <= wrap_now;
        last_r    <= last_now;
        plays_r   <= 2'd0;
        restart_r <= 1'b0;
      end
      if (cmd.tune_a) begin
        if (tmp >= RS_S) begin
          tempo_r <= tmp - RS_S;
          due_r   <= 2'd2;
        end else if (tmp <= -RS_S) begin
          tempo_r <= tmp + RS_S;
          due_r   <= 2'd0;
        end else begin
          tempo_r <= tmp;
          due_r   <= 2'd1;
        end
      end
      if (cmd.tune_b) begin
        if (due_r == 2'd0) begin
          plays_r <= 2'd0;
        end else if (c1 >= RF) begin
          tune_cnt_r <= '0;
          tempo_r    <= '0;
          restart_r  <= 1'b1;
          plays_r    <= 2'd0;
        end else if (due_r == 2'd2) begin
          if (c2 >= RF) begin
            tune_cnt_r <= '0;
            tempo_r    <= '0;
            restart_r  <= 1'b1;
            plays_r    <= 2'd1;
          end else begin
            tune_cnt_r <= c2;
            plays_r    <= 2'd2;
          end
        end else begin
          tune_cnt_r <= c1;
          plays_r    <= 2'd1;
        end
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {5'd0, restart_r, plays_r, frame_r, reload_r, rd_data_r};
        out_last_r  <= last_r;
        out_user_r  <= wrap_r;
        n_r         <= n_r + LW'(1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/raster_color_tick_sequencer_top.sv =====
`timescale 1ns / 1ps
// Raster colour sequencer, paced by an external timer.
// Input stream: in_tuser selects the transaction kind (load entry, start,
// tick, stop); in_tdata carries the entry index and colour for loads.
// Output stream: one transaction per colour write; out_tlast marks the
// final write of a tick, out_tuser marks a table wrap (frame done).
// Configuration is a plain write port, taken at any edge with cfg_we high.
// Input is taken only while the sequencer is idle. Loads and stops are done
// at acceptance. A start goes through acceptance, the line product, then a
// reciprocal multiply by 1/1000 and the remainder step for the reload split.
// A tick while running goes through acceptance and the reload dither, then
// per colour write a table read, a step and the output load, with the tempo
// update before the output load on a wrap with music enabled; writes per
// tick are min(lines_per_tick, MAX_LINES), ending early at a table wrap.
// The output register holds a transaction until out_tready; while it is
// stalled the sequencer waits in its output state and takes no input.
// Synchronous reset clears control, position, frame and tune counters and the
// tempo state and loads the config defaults; the colour table is not cleared.

module raster_color_tick_sequencer_top import rcts_pkg::*; #(
  parameter int TABLE_DEPTH    = 256,
  parameter int RATE_SCALE     = 1024,
  parameter int RESTART_FRAMES = 12000,
  parameter int MAX_LINES      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // entry_index[7:0], entry_color[15:8]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // color_out[7:0], timer_reload[23:8], frames_seen[39:24], tune_plays[41:40],
  // tune_restart[42], zero[47:43]
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tuser,  // frame_done[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycles_per_line_milli <= 16'd63056;
      cfg_r.lines_per_tick        <= 6'd1;
      cfg_r.table_length          <= 9'd256;
      cfg_r.music_enabled         <= 1'b0;
      cfg_r.rate_increment        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CYCLES_PER_LINE: cfg_r.cycles_per_line_milli <= cfg_wdata;
        CFG_LINES_PER_TICK:  cfg_r.lines_per_tick        <= cfg_wdata[5:0];
        CFG_TABLE_LENGTH:    cfg_r.table_length          <= cfg_wdata[8:0];
        CFG_MUSIC_ENABLED:   cfg_r.music_enabled         <= cfg_wdata[0];
        CFG_RATE_INCREMENT:  cfg_r.rate_increment        <= signed'(cfg_wdata[11:0]);
        default: ;
      endcase
    end
  end

  rcts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rcts_datapath #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .RATE_SCALE     (RATE_SCALE),
    .RESTART_FRAMES (RESTART_FRAMES),
    .MAX_LINES      (MAX_LINES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cmd         (cmd),
    .sts         (sts),
    .entry_index (in_tdata[7:0]),
    .entry_color (in_tdata[15:8]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

// ===== tb/raster_color_tick_sequencer_top_tb.sv =====
`timescale 1ns / 1ps

module raster_color_tick_sequencer_top_tb;
  import rcts_pkg::*;

  localparam int TABLE_DEPTH    = 256;
  localparam int RATE_SCALE     = 1024;
  localparam int RESTART_FRAMES = 12000;
  localparam int MAX_LINES      = 32;
  localparam int RANDOM_ITEMS   = 390;
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 400;
  localparam int CYCLE_LIMIT    = 2000000;

  typedef struct packed {
    logic [7:0]  color;
    logic [15:0] reload;
    logic        last;
    logic        frame;
    logic [15:0] frames;
    logic [1:0]  plays;
    logic        restart;
  } color_write_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_e;

  typedef struct packed {
    row_e         what;
    logic [2:0]   reg_idx;
    logic [15:0]  value;
    logic [1:0]   kind;
    logic [7:0]   idx;
    logic [7:0]   col;
    logic         typed;
    color_write_t want;
  } directed_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata  = '0;  // entry_index[7:0], entry_color[15:8]
  logic [1:0]  in_tuser  = KIND_LOAD;  // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // color_out[7:0], timer_reload[23:8], frames_seen[39:24], tune_plays[41:40],
  // tune_restart[42], zero[47:43]
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;  // frame_done[0]
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = CFG_CYCLES_PER_LINE;
  logic [15:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  raster_color_tick_sequencer_top dut (.*);

  // sequencer state as predicted
  cfg_t        shadow;
  logic [7:0]  palette [TABLE_DEPTH];
  bit          palette_loaded [TABLE_DEPTH];
  int          scan_pos;
  int          frac_accum;
  int          frac_per_tick;
  logic [15:0] reload_base;
  logic [15:0] frame_count;
  logic [15:0] tune_count;
  bit          seq_running;
  int          tempo;

  color_write_t expected_writes [$];
  color_write_t fresh_writes [$];
  directed_row_t directed [$];

  bit idle_in      = 1'b1;
  bit idle_out     = 1'b1;
  bit hold_request = 1'b0;
  int errors;
  int results_checked;
  int items_sent;
  int cycle_count;

  function automatic void compute_color_writes(input logic [1:0] kind, input logic [7:0] idx,
                                               input logic [7:0] col);
    int lines;
    int len;
    int total;
    int inc;
    int due;
    int played;
    int n;
    color_write_t w;
    lines = (shadow.lines_per_tick > MAX_LINES) ? MAX_LINES : int'(shadow.lines_per_tick);
    len = (shadow.table_length > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow.table_length);
    fresh_writes.delete();
    case (kind)
      KIND_LOAD: begin
        palette[idx] = col;
        palette_loaded[idx] = 1'b1;
      end
      KIND_START: begin
        total = int'(shadow.cycles_per_line_milli) * lines;
        reload_base = 16'(total / MILLI);
        frac_per_tick = total % MILLI;
        frac_accum = 0;
        scan_pos = 0;
        frame_count = '0;
        seq_running = 1'b1;
      end
      KIND_STOP: seq_running = 1'b0;
      default: if (seq_running) begin
        w = '0;
        frac_accum += frac_per_tick;
        if (frac_accum >= MILLI) begin
          frac_accum -= MILLI;
          w.reload = reload_base + 16'd1;
        end else begin
          w.reload = reload_base;
        end
        for (n = 0; n < lines; n++) begin
          w.color = palette[scan_pos];
          w.frame = 1'b0;
          w.plays = '0;
          w.restart = 1'b0;
          scan_pos++;
          if (scan_pos >= len) begin
            scan_pos = 0;
            frame_count++;
            w.frame = 1'b1;
            if (shadow.music_enabled) begin
              inc = int'($signed(shadow.rate_increment));
              if (inc > RATE_SCALE) inc = RATE_SCALE;
              if (inc < -RATE_SCALE) inc = -RATE_SCALE;
              tempo += inc;
              due = 1;
              if (tempo >= RATE_SCALE) begin
                tempo -= RATE_SCALE;
                due = 2;
              end else if (tempo <= -RATE_SCALE) begin
                tempo += RATE_SCALE;
                due = 0;
              end
              played = 0;
              while (due > 0) begin
                tune_count++;
                if (tune_count >= RESTART_FRAMES) begin
                  // restart takes the place of the play and drops the rest
                  tune_count = '0;
                  tempo = 0;
                  w.restart = 1'b1;
                  break;
                end
                played++;
                due--;
              end
              w.plays = 2'(played);
            end
          end
          w.last = w.frame || (n + 1 == lines);
          w.frames = frame_count;
          fresh_writes.push_back(w);
          if (w.frame) break;
        end
      end
    endcase
  endfunction

  function automatic directed_row_t item_row(input logic [1:0] kind, input logic [7:0] idx,
                                             input logic [7:0] col);
    directed_row_t r;
    r = '0;
    r.what = ROW_ITEM;
    r.kind = kind;
    r.idx = idx;
    r.col = col;
    return r;
  endfunction

  function automatic directed_row_t reg_row(input logic [2:0] idx, input logic [15:0] value);
    directed_row_t r;
    r = '0;
    r.what = ROW_REG;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic directed_row_t typed_tick(input color_write_t want);
    directed_row_t r;
    r = item_row(KIND_TICK, 8'hFF, 8'hFF);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [7:0] idx, input logic [7:0] col,
                           input bit typed = 1'b0, input color_write_t want = '0);
    while (idle_in && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {col, idx};
    do @(posedge clk); while (in_tready !== 1'b1);
    compute_color_writes(kind, idx, col);
    if (typed) begin
      expected_writes.push_back(want);
    end else begin
      foreach (fresh_writes[i]) expected_writes.push_back(fresh_writes[i]);
    end
    items_sent++;
  endtask

  task automatic send_counted(input logic [1:0] kind);
    send_item(kind, 8'($urandom), 8'($urandom));
  endtask

  task automatic drain_and_wait();
    in_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CYCLES_PER_LINE: shadow.cycles_per_line_milli = value;
      CFG_LINES_PER_TICK:  shadow.lines_per_tick = value[5:0];
      CFG_TABLE_LENGTH:    shadow.table_length = value[8:0];
      CFG_MUSIC_ENABLED:   shadow.music_enabled = value[0];
      CFG_RATE_INCREMENT:  shadow.rate_increment = value[11:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // never read an entry that was not loaded
  task automatic fill_table();
    int upto;
    upto = (shadow.table_length > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow.table_length);
    if (upto == 0) upto = 1;
    for (int e = 0; e < upto; e++)
      if (!palette_loaded[e]) send_item(KIND_LOAD, 8'(e), 8'($urandom));
  endtask

  always @(posedge clk) begin
    color_write_t got;
    color_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{color: out_tdata[7:0], reload: out_tdata[23:8], last: out_tlast,
              frame: out_tuser, frames: out_tdata[39:24], plays: out_tdata[41:40],
              restart: out_tdata[42]};
      results_checked++;
      if (expected_writes.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: expected none, actual %h", $time, got);
      end else begin
        want = expected_writes.pop_front();
        check_field("color_out", want.color, got.color);
        check_field("timer_reload", want.reload, got.reload);
        check_field("last_of_tick", want.last, got.last);
        check_field("frame_done", want.frame, got.frame);
        check_field("frames_seen", want.frames, got.frames);
        check_field("tune_plays", want.plays, got.plays);
        check_field("tune_restart", want.restart, got.restart);
        check_field("padding", '0, out_tdata[47:43]);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_tready <= !(idle_out && $urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int phase;
    int ticks;
    int pick;
    logic [15:0] v;

    shadow.cycles_per_line_milli = 16'd63056;
    shadow.lines_per_tick = 6'd1;
    shadow.table_length = 9'd256;
    shadow.music_enabled = 1'b0;
    shadow.rate_increment = '0;
    scan_pos = 0;
    frac_accum = 0;
    frac_per_tick = 0;
    reload_base = '0;
    frame_count = '0;
    tune_count = '0;
    seq_running = 1'b0;
    tempo = 0;

    directed = '{
      item_row(KIND_TICK, 8'h00, 8'h00),
      item_row(KIND_STOP, 8'hFF, 8'hFF),
      item_row(KIND_LOAD, 8'd0, 8'h00),
      item_row(KIND_LOAD, 8'd1, 8'hFF),
      item_row(KIND_LOAD, 8'd2, 8'hA5),
      item_row(KIND_LOAD, 8'd255, 8'h5A),
      reg_row(CFG_CYCLES_PER_LINE, 16'd0),
      reg_row(CFG_TABLE_LENGTH, 16'd1),
      item_row(KIND_START, 8'h00, 8'h00),
      typed_tick('{8'h00, 16'd0, 1'b1, 1'b1, 16'd1, 2'd0, 1'b0}),
      reg_row(CFG_CYCLES_PER_LINE, 16'hFFFF),
      reg_row(CFG_LINES_PER_TICK, 16'd32),
      reg_row(CFG_TABLE_LENGTH, 16'd3),
      item_row(KIND_START, 8'hFF, 8'hFF),
      item_row(KIND_TICK, 8'h00, 8'h00),
      item_row(KIND_STOP, 8'h00, 8'h00),
      item_row(KIND_TICK, 8'h00, 8'h00),
      reg_row(CFG_LINES_PER_TICK, 16'd0),
      item_row(KIND_START, 8'h00, 8'h00),
      item_row(KIND_TICK, 8'h00, 8'h00),
      reg_row(CFG_LINES_PER_TICK, 16'd63),
      reg_row(CFG_TABLE_LENGTH, 16'd0),
      reg_row(CFG_MUSIC_ENABLED, 16'd1),
      reg_row(CFG_RATE_INCREMENT, 16'h07FF),
      typed_tick('{8'h00, 16'd0, 1'b1, 1'b1, 16'd1, 2'd2, 1'b0}),
      reg_row(CFG_RATE_INCREMENT, 16'h0800),
      typed_tick('{8'h00, 16'd0, 1'b1, 1'b1, 16'd2, 2'd0, 1'b0}),
      reg_row(CFG_RATE_INCREMENT, 16'd300),
      reg_row(CFG_TABLE_LENGTH, 16'd2),
      item_row(KIND_TICK, 8'h00, 8'h00),
      item_row(KIND_TICK, 8'h00, 8'h00),
      item_row(KIND_STOP, 8'h00, 8'h00)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r]) begin
      if (directed[r].what == ROW_REG) begin
        drain_and_wait();
        write_reg(directed[r].reg_idx, directed[r].value);
      end else begin
        send_item(directed[r].kind, directed[r].idx, directed[r].col,
                  directed[r].typed, directed[r].want);
      end
    end

    // random phases; configuration only changes with the sequencer drained
    for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      drain_and_wait();
      idle_in = !(phase >= 4 && phase < 9);
      idle_out = idle_in;

      if (phase == 0 || $urandom_range(2) == 0) begin
        case ($urandom_range(4))
          0: v = 16'd0;
          1: v = 16'hFFFF;
          2: v = 16'd63056;
          default: v = 16'($urandom);
        endcase
        write_reg(CFG_CYCLES_PER_LINE, v);
      end
      if (phase == 1 || phase == 6) begin
        write_reg(CFG_LINES_PER_TICK, 16'd32);
      end else if ($urandom_range(1) == 0) begin
        case ($urandom_range(9))
          0: v = 16'd0;
          1: v = 16'd32;
          2: v = 16'($urandom_range(33, 63));
          default: v = 16'($urandom_range(1, 8));
        endcase
        write_reg(CFG_LINES_PER_TICK, v);
      end
      if (phase == 6) begin
        write_reg(CFG_TABLE_LENGTH, 16'($urandom_range(257, 511)));
      end else if (phase == 1) begin
        write_reg(CFG_TABLE_LENGTH, 16'($urandom_range(20, 24)));
      end else if ($urandom_range(1) == 0) begin
        case ($urandom_range(19))
          0: v = 16'd0;
          1: v = 16'($urandom_range(24, 511));
          default: v = 16'($urandom_range(1, 24));
        endcase
        write_reg(CFG_TABLE_LENGTH, v);
      end
      if ($urandom_range(1) == 0) write_reg(CFG_MUSIC_ENABLED, 16'($urandom));
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(7))
          0: v = 16'd1024;
          1: v = 16'hFC00;
          2: v = 16'h07FF;
          3: v = 16'h0800;
          4: v = 16'($urandom_range(0, 128)) - 16'd64;
          default: v = 16'($urandom);
        endcase
        write_reg(CFG_RATE_INCREMENT, v);
      end

      fill_table();
      if (phase == 1) hold_request = 1'b1;

      if (!seq_running || phase == 6 || $urandom_range(3) == 0) send_counted(KIND_START);
      ticks = (phase == 6) ? 12 : $urandom_range(3, 14);
      repeat (ticks) begin
        pick = $urandom_range(19);
        case (pick)
          0: send_counted(KIND_LOAD);
          1: begin
            send_counted(KIND_STOP);
            send_counted(KIND_TICK);
            send_counted(KIND_START);
          end
          2: send_counted(KIND_START);
          default: send_counted(KIND_TICK);
        endcase
      end
      if ($urandom_range(4) == 0) send_counted(KIND_STOP);
    end

    // every tick wraps at a table length of one, with the tempo rate at full scale
    drain_and_wait();
    idle_in = 1'b1;
    idle_out = 1'b1;
    write_reg(CFG_TABLE_LENGTH, 16'd1);
    write_reg(CFG_MUSIC_ENABLED, 16'd1);
    write_reg(CFG_RATE_INCREMENT, 16'd1024);
    fill_table();
    send_item(KIND_START, 8'($urandom), 8'($urandom));
    repeat (20) send_item(KIND_TICK, 8'($urandom), 8'($urandom));

    drain_and_wait();
    $display("run covered %0d input transactions and %0d colour writes checked",
             items_sent, results_checked);
    $display("with saturated registers, tempo rate extremes, full-table wrap and a long stall");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== raster_color_tick_sequencer_top.f =====
rtl/rcts_pkg.sv
rtl/rcts_ctrl.sv
rtl/rcts_datapath.sv
rtl/raster_color_tick_sequencer_top.sv
tb/raster_color_tick_sequencer_top_tb.sv
